// File: sv/rsfag_pkg.sv
package rsfag_pkg;

  // One input word: one control tick from the receiver.
  typedef struct packed {
    logic [10:0] roll_raw;
    logic [10:0] pitch_raw;
    logic [10:0] throttle_raw;
    logic [10:0] yaw_raw;
    logic [10:0] mode_switch_raw;
    logic [15:0] frame_count;
    logic        sdk_key;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [12:0] roll_cmd;
    logic [12:0] pitch_cmd;
    logic [11:0] throttle_cmd;
    logic [12:0] yaw_cmd;
    logic        failsafe;
    logic        armed;
    logic        fly_mode;
  } result_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_CHECK_PERIOD  = 3'd0;
  localparam logic [2:0] REG_ARM_HOLD      = 3'd1;
  localparam logic [2:0] REG_DISARM_HOLD   = 3'd2;
  localparam logic [2:0] REG_STOP_LEVEL    = 3'd3;

  // Register reset values.
  localparam logic [7:0]  CHECK_PERIOD_RST = 8'd20;
  localparam logic [15:0] HOLD_TICKS_RST   = 16'd100;
  localparam logic [10:0] STOP_LEVEL_RST   = 11'd500;

  localparam logic [10:0] CENTRE_RAW = 11'd1024;
  localparam logic [12:0] CMD_CENTRE = 13'd3000;
  localparam logic [12:0] CMD_MIN    = 13'd1800;
  localparam logic [12:0] CMD_MAX    = 13'd4200;
  localparam logic [12:0] THR_MIN    = 13'd2000;
  localparam logic [12:0] THR_MAX    = 13'd4000;

  // Gesture windows are open intervals.
  localparam logic [12:0] GEST_HI_LO = 13'd3900;
  localparam logic [12:0] GEST_HI_HI = 13'd4100;
  localparam logic [12:0] GEST_LO_LO = 13'd1900;
  localparam logic [12:0] GEST_LO_HI = 13'd2100;

  // 125/84 as a fixed-point reciprocal: ceil(125 * 2^24 / 84). The rounding
  // error times the largest magnitude (1024) stays below 1/84, so the
  // truncated quotient is exact over the whole stick range.
  localparam int          SCALE_SHIFT = 24;
  localparam logic [24:0] SCALE_MULT  = 25'd24966096;

endpackage

// File: sv/rc_stick_failsafe_arm_gate.sv
// Receiver failsafe, stick scaling and stick-gesture arming gate. Each input
// word is one control tick and gives exactly one result word. The block is a
// four-register pipeline: an input register, a stage that multiplies each
// stick's offset from centre by a fixed-point reciprocal of 84/125, a stage
// that adds the 3000 offset and applies the throttle clamp and the range
// test, and the result register, which is loaded together with all tick
// state (liveness check phase, failsafe, centre hold, gesture counters and
// the armed flag). A word passes the input register and both stages before
// the result register loads, and a new word can be accepted in every cycle
// while item_stall is low; the result register is the only place where
// state is read and written, so consecutive words see each other's effects
// in order. The configuration port is always ready; registers should only
// be written while no word is in flight.
module rc_stick_failsafe_arm_gate import rsfag_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,

  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [7:0]  check_period;
  logic [15:0] arm_hold_ticks;
  logic [15:0] disarm_hold_ticks;
  logic [10:0] stop_switch_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_period      <= CHECK_PERIOD_RST;
      arm_hold_ticks    <= HOLD_TICKS_RST;
      disarm_hold_ticks <= HOLD_TICKS_RST;
      stop_switch_level <= STOP_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHECK_PERIOD: check_period      <= cfg_data[7:0];
        REG_ARM_HOLD:     arm_hold_ticks    <= cfg_data;
        REG_DISARM_HOLD:  disarm_hold_ticks <= cfg_data;
        REG_STOP_LEVEL:   stop_switch_level <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage loads when it is empty or when its
  // word moves on, so a stalled result only stops the stages behind it once
  // they are all full.
  logic v1, v2, v3;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !result_valid || !result_stall;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign item_stall = !adv1;

  // Stage 1: input register.
  item_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1 <= item;
    end
  end

  // Stage 2: magnitude of each stick's offset from centre times the
  // reciprocal. Lanes are roll, pitch, throttle, yaw.
  logic [10:0] raw1 [4];
  logic [3:0]  neg1;
  logic [10:0] mag1 [4];
  logic [35:0] prod1 [4];

  assign raw1[0] = s1.roll_raw;
  assign raw1[1] = s1.pitch_raw;
  assign raw1[2] = s1.throttle_raw;
  assign raw1[3] = s1.yaw_raw;

  logic [3:0]  neg2;
  logic [10:0] q2 [4];
  logic        all_centre2;
  logic [10:0] sw2;
  logic [15:0] fc2;
  logic        key2;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign neg1[i]  = !raw1[i][10];
    assign mag1[i]  = neg1[i] ? (CENTRE_RAW - raw1[i]) : {1'b0, raw1[i][9:0]};
    assign prod1[i] = 36'(mag1[i]) * 36'(SCALE_MULT);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      for (int i = 0; i < 4; i++) begin
        neg2[i] <= neg1[i];
        q2[i]   <= prod1[i][SCALE_SHIFT +: 11];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      all_centre2 <= (s1.roll_raw == CENTRE_RAW) && (s1.pitch_raw == CENTRE_RAW) &&
                     (s1.throttle_raw == CENTRE_RAW) && (s1.yaw_raw == CENTRE_RAW);
      sw2         <= s1.mode_switch_raw;
      fc2         <= s1.frame_count;
      key2        <= s1.sdk_key;
    end
  end

  // Stage 3: centre offset, throttle clamp and the range test on the other
  // three sticks. Results here are before any hold or key override.
  logic [12:0] cmd2 [4];
  logic [12:0] lim2 [4];

  for (genvar i = 0; i < 4; i++) begin : g_offset
    assign cmd2[i] = neg2[i] ? (CMD_CENTRE - 13'(q2[i])) : (CMD_CENTRE + 13'(q2[i]));
  end

  always_comb begin
    lim2[0] = (cmd2[0] < CMD_MIN || cmd2[0] > CMD_MAX) ? CMD_CENTRE : cmd2[0];
    lim2[1] = (cmd2[1] < CMD_MIN || cmd2[1] > CMD_MAX) ? CMD_CENTRE : cmd2[1];
    lim2[3] = (cmd2[3] < CMD_MIN || cmd2[3] > CMD_MAX) ? CMD_CENTRE : cmd2[3];
    if (cmd2[2] < THR_MIN) begin
      lim2[2] = THR_MIN;
    end else if (cmd2[2] > THR_MAX) begin
      lim2[2] = THR_MAX;
    end else begin
      lim2[2] = cmd2[2];
    end
  end

  logic [12:0] lim3 [4];
  logic        all_centre3;
  logic [10:0] sw3;
  logic [15:0] fc3;
  logic        key3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      lim3        <= lim2;
      all_centre3 <= all_centre2;
      sw3         <= sw2;
      fc3         <= fc2;
      key3        <= key2;
    end
  end

  // Stage 4: tick state and the result register.
  logic [7:0]  tick_phase;
  logic [15:0] last_frame_count;
  logic        failsafe_flag;
  logic        hold_centre;
  logic [15:0] arm_gesture_count;
  logic [15:0] disarm_gesture_count;
  logic        armed_flag;

  logic [7:0]  tick_phase_next;
  logic [15:0] last_frame_count_next;
  logic        failsafe_flag_next;
  logic        hold_centre_next;
  logic [15:0] arm_gesture_count_next;
  logic [15:0] disarm_gesture_count_next;
  logic        armed_flag_next;
  result_t     result_next;

  logic        do_check;
  logic        stale;
  logic        hold_a;
  logic        force_centre;
  logic [12:0] thr_cmd, yaw_cmd;
  logic        thr_low, yaw_high, yaw_low;
  logic [15:0] arm_cnt, dis_cnt;
  logic [15:0] arm_need, dis_need;
  logic        arm_hit, dis_hit;
  logic [7:0]  period;
  logic [8:0]  phase_inc;

  always_comb begin
    // Liveness check on the frame counter once per period.
    do_check = (tick_phase == 8'd0);
    stale    = (fc3 == last_frame_count);
    if (do_check) begin
      last_frame_count_next = fc3;
      failsafe_flag_next    = stale;
      hold_a                = stale || hold_centre;
    end else begin
      last_frame_count_next = last_frame_count;
      failsafe_flag_next    = failsafe_flag;
      hold_a                = hold_centre;
    end
    // A new frame releases the centre hold, except on a check tick.
    hold_centre_next = hold_a && (fc3 == last_frame_count_next);
    // Held sticks read as centre, which also counts as all-centre.
    if (hold_centre_next || all_centre3) begin
      failsafe_flag_next = 1'b1;
    end

    // A held stick scales to exactly the centre command.
    force_centre = hold_centre_next || (failsafe_flag_next && key3);
    result_next.roll_cmd     = force_centre ? CMD_CENTRE : lim3[0];
    result_next.pitch_cmd    = force_centre ? CMD_CENTRE : lim3[1];
    thr_cmd                  = force_centre ? CMD_CENTRE : lim3[2];
    yaw_cmd                  = force_centre ? CMD_CENTRE : lim3[3];
    result_next.throttle_cmd = thr_cmd[11:0];
    result_next.yaw_cmd      = yaw_cmd;

    // Gesture counters saturate and clear when the gesture is let go.
    thr_low  = (thr_cmd > GEST_LO_LO) && (thr_cmd < GEST_LO_HI);
    yaw_high = (yaw_cmd > GEST_HI_LO) && (yaw_cmd < GEST_HI_HI);
    yaw_low  = (yaw_cmd > GEST_LO_LO) && (yaw_cmd < GEST_LO_HI);
    arm_cnt  = (thr_low && yaw_high) ?
               ((arm_gesture_count == 16'hFFFF) ? arm_gesture_count : arm_gesture_count + 16'd1)
               : 16'd0;
    dis_cnt  = (thr_low && yaw_low) ?
               ((disarm_gesture_count == 16'hFFFF) ? disarm_gesture_count
                                                   : disarm_gesture_count + 16'd1)
               : 16'd0;

    // A hold of zero behaves as a hold of one.
    arm_need = (arm_hold_ticks == 16'd0) ? 16'd1 : arm_hold_ticks;
    dis_need = (disarm_hold_ticks == 16'd0) ? 16'd1 : disarm_hold_ticks;
    arm_hit  = (arm_cnt >= arm_need);
    // Arming clears both counters first, so disarm cannot fire on that tick.
    dis_hit  = !arm_hit && (dis_cnt >= dis_need);

    if (arm_hit || dis_hit) begin
      arm_gesture_count_next    = 16'd0;
      disarm_gesture_count_next = 16'd0;
    end else begin
      arm_gesture_count_next    = arm_cnt;
      disarm_gesture_count_next = dis_cnt;
    end
    if (arm_hit) begin
      armed_flag_next = 1'b1;
    end else if (dis_hit) begin
      armed_flag_next = 1'b0;
    end else begin
      armed_flag_next = armed_flag;
    end

    // Phase advance; a period of zero checks on every tick, and a phase left
    // above a newly written period wraps to zero.
    period          = (check_period == 8'd0) ? 8'd1 : check_period;
    phase_inc       = {1'b0, tick_phase} + 9'd1;
    tick_phase_next = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];

    result_next.failsafe = failsafe_flag_next;
    result_next.armed    = armed_flag_next;
    result_next.fly_mode = (sw3 <= stop_switch_level);
  end

  logic step;
  assign step = adv4 && v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid         <= 1'b0;
      tick_phase           <= 8'd0;
      last_frame_count     <= 16'd0;
      failsafe_flag        <= 1'b0;
      hold_centre          <= 1'b0;
      arm_gesture_count    <= 16'd0;
      disarm_gesture_count <= 16'd0;
      armed_flag           <= 1'b0;
    end else begin
      if (adv4) begin
        result_valid <= v3;
      end
      if (step) begin
        tick_phase           <= tick_phase_next;
        last_frame_count     <= last_frame_count_next;
        failsafe_flag        <= failsafe_flag_next;
        hold_centre          <= hold_centre_next;
        arm_gesture_count    <= arm_gesture_count_next;
        disarm_gesture_count <= disarm_gesture_count_next;
        armed_flag           <= armed_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // Arming state moves only when a word enters the result register.
  a_armed_only_on_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(armed_flag))
    else $error("armed flag changed without a word");

  // The two gestures are exclusive, so at most one counter runs.
  a_one_gesture: assert property (@(posedge clk) disable iff (rst)
    (arm_gesture_count == 16'd0) || (disarm_gesture_count == 16'd0))
    else $error("arm and disarm counters both running");

  // Throttle in a delivered word is always inside its clamp.
  a_throttle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.throttle_cmd >= THR_MIN[11:0]) &&
                     (result.throttle_cmd <= THR_MAX[11:0]))
    else $error("throttle command out of range");

  // A held centre is always reported as failsafe.
  a_hold_means_failsafe: assert property (@(posedge clk) disable iff (rst)
    hold_centre |-> failsafe_flag)
    else $error("centre hold without failsafe");
`endif

endmodule
